### hw/rtl/ssrm_pkg.sv
`timescale 1ns / 1ps
// Package for the banked sensor register model: types, codes and constants.
// No dependencies; used by all files under hw/rtl.
package ssrm_pkg;

  localparam int NUM_BANKS_DEF = 4;

  localparam logic [6:0]  BANK_BASE   = 7'h48;
  localparam logic [15:0] CFG_RESET   = 16'h0001;
  localparam logic [15:0] HUM_BASE    = 16'd4000;
  localparam logic [4:0]  PH21_LAST   = 5'd20;
  localparam logic [7:0]  PH200_LAST  = 8'd199;
  localparam logic [15:0] HIGH_MASK   = 16'hff00;
  localparam logic [15:0] LOW_MASK    = 16'h00ff;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ARM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_MASK = 8'd1;

  typedef enum logic [1:0] {
    REG_TEMP = 2'd0,
    REG_HUM  = 2'd1,
    REG_CFG  = 2'd2
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DEV  = 2'd1,
    ST_BUS_ERR = 2'd2,
    ST_UNSUP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1
  } size_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DECODE,
    CS_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // (24000 + p*100) * 16 / 1000 for phase p of 0..20
  function automatic logic [15:0] temp_lut(input logic [4:0] p);
    logic [15:0] v;
    unique case (p)
      5'd0:    v = 16'd384;
      5'd1:    v = 16'd385;
      5'd2:    v = 16'd387;
      5'd3:    v = 16'd388;
      5'd4:    v = 16'd390;
      5'd5:    v = 16'd392;
      5'd6:    v = 16'd393;
      5'd7:    v = 16'd395;
      5'd8:    v = 16'd396;
      5'd9:    v = 16'd398;
      5'd10:   v = 16'd400;
      5'd11:   v = 16'd401;
      5'd12:   v = 16'd403;
      5'd13:   v = 16'd404;
      5'd14:   v = 16'd406;
      5'd15:   v = 16'd408;
      5'd16:   v = 16'd409;
      5'd17:   v = 16'd411;
      5'd18:   v = 16'd412;
      5'd19:   v = 16'd414;
      5'd20:   v = 16'd416;
      default: v = 16'd384;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ssrm_ctrl.sv
`timescale 1ns / 1ps
// Controller for the sensor register model: sequences load, decode and commit.
// Depends on ssrm_pkg.
module ssrm_ctrl import ssrm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      CS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CS_DECODE;
        end
      end
      CS_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = CS_EXEC;
      end
      CS_EXEC: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

### hw/rtl/ssrm_datapath.sv
`timescale 1ns / 1ps
// Datapath: bank registers, global counters, config registers and result register.
// Depends on ssrm_pkg.
module ssrm_datapath import ssrm_pkg::*; #(
  parameter int NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [6:0]           in_slave_addr,
  input  logic                 in_operation,
  input  logic [1:0]           in_access_size,
  input  logic [7:0]           in_reg_index,
  input  logic [15:0]          in_write_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_read_data,
  output logic [1:0]           out_status,
  output logic [31:0]          out_transfer_count,
  output logic [31:0]          out_error_count,
  output logic [31:0]          out_ro_write_count,
  output logic [31:0]          out_faults_remaining,
  output logic [31:0]          out_bank_samples
);

  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam logic [6:0] NB = 7'(NUM_BANKS);

  // latched beat
  logic [6:0]  addr_r;
  logic        op_r;
  logic [1:0]  size_r;
  logic [7:0]  regi_r;
  logic [15:0] wdata_r;

  // decoded
  logic          present_r;
  logic          reg_ok_r;
  logic [BW-1:0] bank_r;
  logic [6:0]    off;

  // bank state
  logic [15:0] temp_r  [NUM_BANKS];
  logic [15:0] hum_r   [NUM_BANKS];
  logic [15:0] cfg_r   [NUM_BANKS];
  logic [31:0] cnt_r   [NUM_BANKS];
  logic [4:0]  ph21_r  [NUM_BANKS];
  logic [7:0]  ph200_r [NUM_BANKS];

  // globals
  logic [31:0] xfer_r, xfer_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] ro_r, ro_nxt;
  logic [31:0] faults_r, faults_nxt;
  logic [3:0]  mask_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] rdata_r, rdata_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] samples_r, samples_nxt;

  // bank update
  logic        conv_en, cfg_we;
  logic [15:0] cfg_new, temp_new, hum_new, rval;
  logic [31:0] cnt_new;
  logic [4:0]  ph21_new;
  logic [7:0]  ph200_new;
  logic        wrap;

  assign cfg_ready    = 1'b1;
  assign sts.out_busy = out_valid_r & out_stall;

  assign off = addr_r - BANK_BASE;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r  <= in_slave_addr;
      op_r    <= in_operation;
      size_r  <= in_access_size;
      regi_r  <= in_reg_index;
      wdata_r <= in_write_data;
    end
    if (cmd.decode) begin
      present_r <= (addr_r >= BANK_BASE) && (off < NB) && ((off >= 7'd4) || mask_r[off[1:0]]);
      reg_ok_r  <= (regi_r < 8'd3);
      bank_r    <= off[BW-1:0];
    end
  end

  // conversion values for the addressed bank
  always_comb begin
    cnt_new   = cnt_r[bank_r] + 32'd1;
    wrap      = (cnt_new == 32'd0);
    ph21_new  = (wrap || ph21_r[bank_r] == PH21_LAST) ? 5'd0 : ph21_r[bank_r] + 5'd1;
    ph200_new = (wrap || ph200_r[bank_r] == PH200_LAST) ? 8'd0 : ph200_r[bank_r] + 8'd1;
    temp_new  = temp_lut(ph21_new);
    hum_new   = HUM_BASE + {8'd0, ph200_new};
  end

  always_comb begin
    xfer_nxt      = xfer_r;
    err_nxt       = err_r;
    ro_nxt        = ro_r;
    faults_nxt    = faults_r;
    out_valid_nxt = out_valid_r & out_stall;
    rdata_nxt     = rdata_r;
    status_nxt    = status_r;
    samples_nxt   = samples_r;
    conv_en       = 1'b0;
    cfg_we        = 1'b0;
    cfg_new       = cfg_r[bank_r];
    rval          = 16'd0;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      rdata_nxt     = 16'd0;
      status_nxt    = ST_OK;
      if (!present_r) begin
        status_nxt = ST_NO_DEV;
      end else if (!reg_ok_r) begin
        status_nxt = ST_BUS_ERR;
      end else begin
        xfer_nxt = xfer_r + 32'd1;
        if (faults_r != 32'd0) begin
          faults_nxt = faults_r - 32'd1;
          err_nxt    = err_r + 32'd1;
          status_nxt = ST_BUS_ERR;
        end else if (size_r != SIZE_BYTE && size_r != SIZE_WORD) begin
          err_nxt    = err_r + 32'd1;
          status_nxt = ST_UNSUP;
        end else if (op_r == OP_READ) begin
          unique case (regi_r[1:0])
            REG_TEMP: begin
              conv_en = 1'b1;
              rval    = temp_new;
            end
            REG_HUM: rval = hum_r[bank_r];
            default: rval = cfg_r[bank_r];
          endcase
          rdata_nxt = (size_r == SIZE_BYTE) ? (rval & LOW_MASK) : rval;
        end else if (regi_r[1:0] != REG_CFG) begin
          ro_nxt     = ro_r + 32'd1;
          err_nxt    = err_r + 32'd1;
          status_nxt = ST_BUS_ERR;
        end else begin
          cfg_we  = 1'b1;
          cfg_new = (size_r == SIZE_BYTE) ?
                    ((cfg_r[bank_r] & HIGH_MASK) | (wdata_r & LOW_MASK)) : wdata_r;
        end
      end
      samples_nxt = !present_r ? 32'd0 : (conv_en ? cnt_new : cnt_r[bank_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        temp_r[i]  <= 16'd0;
        hum_r[i]   <= 16'd0;
        cfg_r[i]   <= CFG_RESET;
        cnt_r[i]   <= 32'd0;
        ph21_r[i]  <= 5'd0;
        ph200_r[i] <= 8'd0;
      end
    end else begin
      if (conv_en) begin
        cnt_r[bank_r]   <= cnt_new;
        ph21_r[bank_r]  <= ph21_new;
        ph200_r[bank_r] <= ph200_new;
        temp_r[bank_r]  <= temp_new;
        hum_r[bank_r]   <= hum_new;
      end
      if (cfg_we) begin
        cfg_r[bank_r] <= cfg_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfer_r      <= 32'd0;
      err_r       <= 32'd0;
      ro_r        <= 32'd0;
      faults_r    <= 32'd0;
      mask_r      <= 4'hf;
      out_valid_r <= 1'b0;
    end else begin
      xfer_r      <= xfer_nxt;
      err_r       <= err_nxt;
      ro_r        <= ro_nxt;
      out_valid_r <= out_valid_nxt;
      faults_r    <= faults_nxt;
      if (cfg_valid && cfg_index == CFG_FAULT_ARM) begin
        faults_r <= cfg_wdata;
      end
      if (cfg_valid && cfg_index == CFG_BANK_MASK) begin
        mask_r <= cfg_wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r   <= rdata_nxt;
    status_r  <= status_nxt;
    samples_r <= samples_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = rdata_r;
  assign out_status           = status_r;
  assign out_transfer_count   = xfer_r;
  assign out_error_count      = err_r;
  assign out_ro_write_count   = ro_r;
  assign out_faults_remaining = faults_r;
  assign out_bank_samples     = samples_r;

endmodule

### hw/rtl/smbus_sensor_register_model_unit.sv
`timescale 1ns / 1ps
// Top level of the banked sensor register model: controller plus datapath.
// Depends on ssrm_pkg, ssrm_ctrl and ssrm_datapath.
// Input beat to result beat: load, decode and commit, the result being registered.
// Throughput: one access at a time, stepping through the controller's three states;
// a result held by out_stall delays the commit of the following access.
// Reset: synchronous on rst_n low; banks back to config 1, counters and faults 0, mask 0xf.
module smbus_sensor_register_model_unit import ssrm_pkg::*; #(
  parameter int NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [6:0]           in_slave_addr,
  input  logic                 in_operation,
  input  logic [1:0]           in_access_size,
  input  logic [7:0]           in_reg_index,
  input  logic [15:0]          in_write_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_read_data,
  output logic [1:0]           out_status,
  output logic [31:0]          out_transfer_count,
  output logic [31:0]          out_error_count,
  output logic [31:0]          out_ro_write_count,
  output logic [31:0]          out_faults_remaining,
  output logic [31:0]          out_bank_samples
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ssrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssrm_datapath #(
    .NUM_BANKS (NUM_BANKS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_slave_addr        (in_slave_addr),
    .in_operation         (in_operation),
    .in_access_size       (in_access_size),
    .in_reg_index         (in_reg_index),
    .in_write_data        (in_write_data),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_data        (out_read_data),
    .out_status           (out_status),
    .out_transfer_count   (out_transfer_count),
    .out_error_count      (out_error_count),
    .out_ro_write_count   (out_ro_write_count),
    .out_faults_remaining (out_faults_remaining),
    .out_bank_samples     (out_bank_samples)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for smbus_sensor_register_model_unit: a directed table then random
// bank accesses, each result checked against an in-bench model of the sensor banks.
// Depends on ssrm_pkg and the unit's RTL only.
module testbench;
  import ssrm_pkg::*;

  localparam int NUM_BANKS      = NUM_BANKS_DEF;
  localparam int RESULT_LATENCY = 3;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 105;
  localparam logic [1:0] SIZE_ODD_A = 2'd2;
  localparam logic [1:0] SIZE_ODD_B = 2'd3;

  typedef struct packed {
    logic [6:0]  addr;
    logic        op;
    logic [1:0]  size;
    logic [7:0]  regi;
    logic [15:0] wdata;
  } access_t;

  typedef struct packed {
    logic [15:0] rdata;
    status_t     status;
    logic [31:0] xfers;
    logic [31:0] errs;
    logic [31:0] ro_wr_cnt;
    logic [31:0] faults;
    logic [31:0] samples;
  } report_t;

  typedef struct packed {
    logic           setting;
    logic [7:0]     idx;
    logic [31:0]    val;
    access_t        acc;
    logic           chk;
    status_t        st;
    logic [15:0]    rdata;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [6:0] in_slave_addr;
  logic in_operation;
  logic [1:0] in_access_size;
  logic [7:0] in_reg_index;
  logic [15:0] in_write_data;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic out_valid, out_stall;
  logic [15:0] out_read_data;
  logic [1:0] out_status;
  logic [31:0] out_transfer_count, out_error_count, out_ro_write_count;
  logic [31:0] out_faults_remaining, out_bank_samples;

  // typed-in expectation travelling with the beat
  logic        tag_chk;
  status_t     tag_status;
  logic [15:0] tag_rdata;

  logic [15:0] bank_temp [NUM_BANKS];
  logic [15:0] bank_humidity [NUM_BANKS];
  logic [15:0] bank_config [NUM_BANKS];
  logic [31:0] bank_sample_ctr [NUM_BANKS];
  logic [31:0] total_xfers, total_errors, total_ro_wr, faults_pending;
  logic [3:0]  present_mask;

  report_t   pending_reports[$];
  plan_row_t plan[$];
  int        fail_count = 0;
  bit        quiet = 1'b0;

  always #2 clk = ~clk;

  smbus_sensor_register_model_unit #(.NUM_BANKS(NUM_BANKS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_slave_addr(in_slave_addr), .in_operation(in_operation),
    .in_access_size(in_access_size), .in_reg_index(in_reg_index),
    .in_write_data(in_write_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_status(out_status),
    .out_transfer_count(out_transfer_count), .out_error_count(out_error_count),
    .out_ro_write_count(out_ro_write_count), .out_faults_remaining(out_faults_remaining),
    .out_bank_samples(out_bank_samples)
  );

  function automatic report_t sensor_access(input access_t a);
    report_t     r;
    logic [1:0]  bank;
    logic        present;
    logic [31:0] s;
    logic [15:0] cur;
    r = '0;
    r.status = ST_OK;
    bank = '0;
    present = 1'b0;
    if (a.addr >= BANK_BASE && a.addr < BANK_BASE + NUM_BANKS) begin
      bank = 2'(a.addr - BANK_BASE);
      present = present_mask[bank];
    end
    if (!present) begin
      r.status = ST_NO_DEV;
    end else if (a.regi > 8'(REG_CFG)) begin
      r.status = ST_BUS_ERR;
    end else begin
      total_xfers++;
      if (faults_pending != 0) begin
        faults_pending--;
        total_errors++;
        r.status = ST_BUS_ERR;
      end else if (a.size != SIZE_BYTE && a.size != SIZE_WORD) begin
        total_errors++;
        r.status = ST_UNSUP;
      end else if (a.op == OP_READ) begin
        if (a.regi == 8'(REG_TEMP)) begin
          s = bank_sample_ctr[bank] + 1;
          bank_sample_ctr[bank] = s;
          bank_temp[bank] = 16'((32'd24000 + (s % 21) * 100) * 16 / 1000);
          bank_humidity[bank] = 16'(32'd4000 + s % 200);
        end
        if (a.regi == 8'(REG_TEMP)) cur = bank_temp[bank];
        else if (a.regi == 8'(REG_HUM)) cur = bank_humidity[bank];
        else cur = bank_config[bank];
        r.rdata = (a.size == SIZE_BYTE) ? (cur & LOW_MASK) : cur;
      end else if (a.regi != 8'(REG_CFG)) begin
        total_ro_wr++;
        total_errors++;
        r.status = ST_BUS_ERR;
      end else if (a.size == SIZE_BYTE) begin
        bank_config[bank] = (bank_config[bank] & HIGH_MASK) | (a.wdata & LOW_MASK);
      end else begin
        bank_config[bank] = a.wdata;
      end
    end
    r.xfers     = total_xfers;
    r.errs      = total_errors;
    r.ro_wr_cnt = total_ro_wr;
    r.faults    = faults_pending;
    r.samples   = present ? bank_sample_ctr[bank] : 32'd0;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp, input logic [31:0] got);
    if (exp !== got) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      fail_count++;
    end
  endtask

  task automatic add_row(input logic [6:0] addr, input logic op, input logic [1:0] size,
                         input logic [7:0] regi, input logic [15:0] wdata, input logic chk,
                         input status_t st, input logic [15:0] rdata);
    plan_row_t p;
    p = '0;
    p.acc = {addr, op, size, regi, wdata};
    p.chk = chk;
    p.st = st;
    p.rdata = rdata;
    plan.push_back(p);
  endtask

  task automatic add_setting(input logic [7:0] idx, input logic [31:0] val);
    plan_row_t p;
    p = '0;
    p.setting = 1'b1;
    p.idx = idx;
    p.val = val;
    plan.push_back(p);
  endtask

  task automatic send_access(input access_t a, input logic chk, input status_t st,
                             input logic [15:0] rdata);
    in_valid       <= 1'b1;
    in_slave_addr  <= a.addr;
    in_operation   <= a.op;
    in_access_size <= a.size;
    in_reg_index   <= a.regi;
    in_write_data  <= a.wdata;
    tag_chk        <= chk;
    tag_status     <= st;
    tag_rdata      <= rdata;
    do @(posedge clk); while (in_stall);
  endtask

  // leaves cfg_valid high; the caller lowers it once the last write is done
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    access_t a;
    report_t r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FAULT_ARM) faults_pending = cfg_wdata;
        else if (cfg_index == CFG_BANK_MASK) present_mask = cfg_wdata[3:0];
      end
      if (in_valid && !in_stall) begin
        a = {in_slave_addr, in_operation, in_access_size, in_reg_index, in_write_data};
        r = sensor_access(a);
        if (tag_chk) begin
          r.status = tag_status;
          r.rdata = tag_rdata;
        end
        pending_reports.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          r = pending_reports.pop_front();
          compare_field("read_data", 32'(r.rdata), 32'(out_read_data));
          compare_field("status", 32'(r.status), 32'(out_status));
          compare_field("transfer_count", r.xfers, out_transfer_count);
          compare_field("error_count", r.errs, out_error_count);
          compare_field("ro_write_count", r.ro_wr_cnt, out_ro_write_count);
          compare_field("faults_remaining", r.faults, out_faults_remaining);
          compare_field("bank_samples", r.samples, out_bank_samples);
        end
      end
    end
  end

  initial begin : result_side
    int n;
    out_stall = 1'b0;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    access_t     a;
    logic [31:0] fault_val;
    logic [3:0]  mask_val;
    int          g;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_slave_addr = '0;
    in_operation = OP_WRITE;
    in_access_size = SIZE_BYTE;
    in_reg_index = '0;
    in_write_data = '0;
    tag_chk = 1'b0;
    tag_status = ST_OK;
    tag_rdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FAULT_ARM;
    cfg_wdata = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      bank_temp[i] = '0;
      bank_humidity[i] = '0;
      bank_config[i] = CFG_RESET;
      bank_sample_ctr[i] = '0;
    end
    total_xfers = '0;
    total_errors = '0;
    total_ro_wr = '0;
    faults_pending = '0;
    present_mask = 4'hf;

    // addr, op, size, reg, wdata, typed-in check, status, read_data
    add_row(7'h48, OP_READ,  SIZE_BYTE,  8'(REG_TEMP), 16'h0000, 1'b1, ST_OK, 16'd129);
    add_row(7'h48, OP_READ,  SIZE_WORD,  8'(REG_TEMP), 16'h0000, 1'b1, ST_OK, 16'd387);
    add_row(7'h48, OP_READ,  SIZE_WORD,  8'(REG_HUM),  16'h0000, 1'b1, ST_OK, 16'd4002);
    add_row(7'h49, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'h0001);
    add_row(7'h49, OP_WRITE, SIZE_WORD,  8'(REG_CFG),  16'habcd, 1'b1, ST_OK, 16'h0000);
    add_row(7'h49, OP_WRITE, SIZE_BYTE,  8'(REG_CFG),  16'h1234, 1'b1, ST_OK, 16'h0000);
    add_row(7'h49, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'hab34);
    add_row(7'h49, OP_READ,  SIZE_BYTE,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'h0034);
    add_row(7'h4a, OP_WRITE, SIZE_WORD,  8'(REG_TEMP), 16'hffff, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h4b, OP_WRITE, SIZE_BYTE,  8'(REG_HUM),  16'h00ff, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h48, OP_READ,  SIZE_ODD_A, 8'(REG_TEMP), 16'h0000, 1'b1, ST_UNSUP, 16'h0000);
    add_row(7'h4a, OP_WRITE, SIZE_ODD_B, 8'(REG_CFG),  16'h5555, 1'b1, ST_UNSUP, 16'h0000);
    add_row(7'h47, OP_READ,  SIZE_WORD,  8'(REG_TEMP), 16'h0000, 1'b1, ST_NO_DEV, 16'h0000);
    add_row(7'h4c, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_NO_DEV, 16'h0000);
    add_row(7'h00, OP_READ,  SIZE_BYTE,  8'(REG_TEMP), 16'h0000, 1'b1, ST_NO_DEV, 16'h0000);
    add_row(7'h7f, OP_WRITE, SIZE_ODD_B, 8'hff,        16'hffff, 1'b1, ST_NO_DEV, 16'h0000);
    add_row(7'h48, OP_READ,  SIZE_WORD,  8'd3,         16'h0000, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h4b, OP_WRITE, SIZE_WORD,  8'hff,        16'hffff, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h4b, OP_WRITE, SIZE_WORD,  8'(REG_CFG),  16'hffff, 1'b1, ST_OK, 16'h0000);
    add_row(7'h4b, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'hffff);
    add_row(7'h4b, OP_READ,  SIZE_WORD,  8'(REG_TEMP), 16'h0000, 1'b1, ST_OK, 16'd385);
    add_setting(CFG_FAULT_ARM, 32'd2);
    add_row(7'h4a, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h4a, OP_WRITE, SIZE_WORD,  8'(REG_CFG),  16'h0f0f, 1'b1, ST_BUS_ERR, 16'h0000);
    add_row(7'h4a, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'h0001);
    add_setting(CFG_BANK_MASK, 32'ha);
    add_row(7'h48, OP_READ,  SIZE_WORD,  8'(REG_TEMP), 16'h0000, 1'b1, ST_NO_DEV, 16'h0000);
    add_row(7'h49, OP_READ,  SIZE_WORD,  8'(REG_CFG),  16'h0000, 1'b1, ST_OK, 16'hab34);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].setting) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_access(plan[i].acc, plan[i].chk, plan[i].st, plan[i].rdata);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin fault_val = 32'd0;          mask_val = 4'hf; end
        1: begin fault_val = 32'hffff_ffff;  mask_val = 4'hf; end
        2: begin fault_val = 32'd0;          mask_val = 4'h0; end
        default: begin
          fault_val = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 6)) : 32'd0;
          mask_val = 4'($urandom_range(0, 15));
        end
      endcase
      wait_idle();
      quiet = (phase == 3);
      write_reg(CFG_FAULT_ARM, fault_val);
      write_reg(CFG_BANK_MASK, {28'd0, mask_val});
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly accesses that reach a bank, the rest noise
        a.addr  = ($urandom_range(0, 99) < 85) ? 7'(BANK_BASE + $urandom_range(0, 3))
                                               : 7'($urandom_range(0, 127));
        a.op    = 1'($urandom_range(0, 1));
        a.size  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                              : 2'($urandom_range(0, 1));
        a.regi  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 2));
        a.wdata = 16'($urandom);
        if ((phase == 4 && n == 50) || $urandom_range(0, 79) == 0) wait_idle();
        send_access(a, 1'b0, ST_OK, 16'h0000);
        g = quiet ? 0 : gap_len();
        if (g != 0) begin
          in_valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
